/* hdl/ow_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_pkg
// shared types, widths and codes of the 1-wire byte engine
// ----------------------------------------------------------------------------
package ow_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 10;
	localparam int CountW = 10;
	localparam int InDataW = 16;
	localparam int OutDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_RESET_LOW = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RESET_RELEASE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PRES_WAIT_MAX = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PRES_LOW_MAX = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WR_ONE_LOW = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WR_ZERO_LOW = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_RD_LOW = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_RD_RECOVER = 3'd7;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [CountW-1:0] WR_ONE_RECOVER_US = 10'd58;
	localparam logic [CountW-1:0] WR_ZERO_RECOVER_US = 10'd2;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [7:0] reset_release_us;
		logic [7:0] presence_wait_max;
		logic [9:0] presence_low_max;
		logic [7:0] write_one_low_us;
		logic [7:0] write_zero_low_us;
		logic [7:0] read_low_us;
		logic [7:0] read_recover_us;
	} cfg_t;

endpackage

/* hdl/ow_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_regs
// timing configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module ow_regs
	import ow_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us      <= 10'd500;
			cfg_q.reset_release_us  <= 8'd15;
			cfg_q.presence_wait_max <= 8'd100;
			cfg_q.presence_low_max  <= 10'd240;
			cfg_q.write_one_low_us  <= 8'd10;
			cfg_q.write_zero_low_us <= 8'd70;
			cfg_q.read_low_us       <= 8'd10;
			cfg_q.read_recover_us   <= 8'd45;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RESET_LOW:     cfg_q.reset_low_us      <= cfg_wdata;
				REG_RESET_RELEASE: cfg_q.reset_release_us  <= cfg_wdata[7:0];
				REG_PRES_WAIT_MAX: cfg_q.presence_wait_max <= cfg_wdata[7:0];
				REG_PRES_LOW_MAX:  cfg_q.presence_low_max  <= cfg_wdata;
				REG_WR_ONE_LOW:    cfg_q.write_one_low_us  <= cfg_wdata[7:0];
				REG_WR_ZERO_LOW:   cfg_q.write_zero_low_us <= cfg_wdata[7:0];
				REG_RD_LOW:        cfg_q.read_low_us       <= cfg_wdata[7:0];
				REG_RD_RECOVER:    cfg_q.read_recover_us   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/one_wire_master_byte_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_byte_engine
// 1-wire bus master: reset with presence check, byte write, byte read
// ----------------------------------------------------------------------------
// Every cycle the host offers one item on the s_ stream: a command slot, the
// synchronized line level and the one-microsecond tick strobe. A command is
// taken only while idle and ignored while busy. All slot timing counts ticks.
// Each input item yields exactly one result item on the m_ stream with the
// line drive, busy, done pulse, last read byte and presence failure flag.
// The item is registered at the input and the result is computed in one pass
// of the phase logic into the output register; one item per cycle is
// sustained while the m_ side does not stall.
// When the m_ side stalls the output register holds; the input register
// takes one more item only while it is empty, and s_tready stays low until the result drains.
// Reset (arst_n low) clears the valid flags of both pipeline registers, sets the engine idle,
// clears the flags and the read byte, and loads the default slot timings.
// Timing registers are written through cfg_we / cfg_addr / cfg_wdata.
// ----------------------------------------------------------------------------
module one_wire_master_byte_engine
	import ow_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// command[1:0], write_data[9:2], line_level[10], us_tick[11], zero pad
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// drive_low[0], busy_res[1], done_res[2], read_data[10:3],
	// presence_fail[11], zero pad
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RST_LOW   = 4'd1;
	localparam logic [3:0] PH_RST_REL   = 4'd2;
	localparam logic [3:0] PH_PRES_WAIT = 4'd3;
	localparam logic [3:0] PH_PRES_LOW  = 4'd4;
	localparam logic [3:0] PH_WR_LOW    = 4'd5;
	localparam logic [3:0] PH_WR_REC    = 4'd6;
	localparam logic [3:0] PH_RD_LOW    = 4'd7;
	localparam logic [3:0] PH_RD_SAMPLE = 4'd8;
	localparam logic [3:0] PH_RD_REC    = 4'd9;

	cfg_t cfg;

	ow_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	logic               valid_s1;
	logic [11:0]        item_s1;
	logic               adv;

	logic [3:0]         phase_q, phase_n;
	logic [CountW-1:0]  cnt_q, cnt_n, cnt_inc, tgt;
	logic [2:0]         bit_q, bit_n;
	logic [7:0]         shift_q, shift_n;
	logic               fail_q, fail_n;
	logic [7:0]         rd_hold_q, rd_hold_n;
	logic               done;
	logic               hit;
	logic               cur_bit;

	logic [1:0]         cmd;
	logic [7:0]         wdata;
	logic               line;
	logic               tick;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata[11:0];
		end
	end

	assign cmd     = item_s1[1:0];
	assign wdata   = item_s1[9:2];
	assign line    = item_s1[10];
	assign tick    = item_s1[11];
	assign cur_bit = shift_q[bit_q];
	assign cnt_inc = cnt_q + 10'd1;

	// slot length for the current phase
	always_comb begin
		case (phase_q)
			PH_RST_LOW:   tgt = cfg.reset_low_us;
			PH_RST_REL:   tgt = {2'b00, cfg.reset_release_us};
			PH_PRES_WAIT: tgt = {2'b00, cfg.presence_wait_max};
			PH_PRES_LOW:  tgt = cfg.presence_low_max;
			PH_WR_LOW:    tgt = cur_bit ? {2'b00, cfg.write_one_low_us}
			                            : {2'b00, cfg.write_zero_low_us};
			PH_WR_REC:    tgt = cur_bit ? WR_ONE_RECOVER_US : WR_ZERO_RECOVER_US;
			PH_RD_LOW:    tgt = {2'b00, cfg.read_low_us};
			PH_RD_REC:    tgt = {2'b00, cfg.read_recover_us};
			default:      tgt = '0;
		endcase
	end

	assign hit = tick && ((cnt_inc >= tgt) || (cnt_inc == '0));

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		bit_n     = bit_q;
		shift_n   = shift_q;
		fail_n    = fail_q;
		rd_hold_n = rd_hold_q;
		done      = 1'b0;
		if (tick) begin
			cnt_n = hit ? '0 : cnt_inc;
		end
		case (phase_q)
			PH_IDLE: begin
				cnt_n = '0;
				bit_n = '0;
				case (cmd)
					CMD_RESET: begin
						fail_n  = 1'b0;
						phase_n = PH_RST_LOW;
					end
					CMD_WRITE: begin
						shift_n = wdata;
						phase_n = PH_WR_LOW;
					end
					CMD_READ: begin
						shift_n = '0;
						phase_n = PH_RD_LOW;
					end
					default: ;
				endcase
			end
			PH_RST_LOW: begin
				if (hit) phase_n = PH_RST_REL;
			end
			PH_RST_REL: begin
				if (hit) phase_n = PH_PRES_WAIT;
			end
			PH_PRES_WAIT: begin
				if (!line) begin
					cnt_n   = '0;
					phase_n = PH_PRES_LOW;
				end else if (hit) begin
					fail_n  = 1'b1;
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_PRES_LOW: begin
				if (line) begin
					cnt_n   = '0;
					phase_n = PH_IDLE;
					done    = 1'b1;
				end else if (hit) begin
					fail_n  = 1'b1;
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_WR_LOW: begin
				if (hit) phase_n = PH_WR_REC;
			end
			PH_WR_REC: begin
				if (hit) begin
					if (bit_q == 3'd7) begin
						bit_n   = '0;
						phase_n = PH_IDLE;
						done    = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_WR_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				if (hit) phase_n = PH_RD_SAMPLE;
			end
			PH_RD_SAMPLE: begin
				shift_n = {line, shift_q[7:1]};
				cnt_n   = '0;
				phase_n = PH_RD_REC;
			end
			PH_RD_REC: begin
				if (hit) begin
					if (bit_q == 3'd7) begin
						bit_n     = '0;
						rd_hold_n = shift_q;
						phase_n   = PH_IDLE;
						done      = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_RD_LOW;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			fail_q    <= 1'b0;
			rd_hold_q <= '0;
		end else if (valid_s1 && adv) begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			bit_q     <= bit_n;
			shift_q   <= shift_n;
			fail_q    <= fail_n;
			rd_hold_q <= rd_hold_n;
		end
	end

	logic drive_n;
	logic busy_n;

	assign drive_n = (phase_n == PH_RST_LOW) || (phase_n == PH_WR_LOW) ||
	                 (phase_n == PH_RD_LOW);
	assign busy_n  = (phase_n != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			m_tdata <= {4'b0000, fail_n, rd_hold_n, done, busy_n, drive_n};
		end
	end

endmodule

/* hdl/ow_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_chk
// port-level checks of the 1-wire byte engine, bound to the top level
// ----------------------------------------------------------------------------
module ow_chk
	import ow_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	// a finishing command leaves the engine idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1])
		else $error("done with busy set");

	// the line is only pulled low inside a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("drive low while idle");

	// an empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled output item changed");

endmodule

bind one_wire_master_byte_engine ow_chk u_ow_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
